[src/cbpm_pkg.sv]
package cbpm_pkg;

    localparam int OP_W   = 2;
    localparam int WORD_W = 32;

    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd0;
    localparam logic [OP_W-1:0] OP_RECORD  = 2'd1;
    localparam logic [OP_W-1:0] OP_MEASURE = 2'd2;

    typedef logic [WORD_W-1:0] word_t;

    typedef struct packed {
        logic  high;
        word_t stamp;
    } edge_info_t;

endpackage

[src/cbpm_mem.sv]
module cbpm_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [AW-1:0]         waddr,
    input  cbpm_pkg::word_t       wdata,
    input  cbpm_pkg::word_t       wtime,
    input  logic [AW-1:0]         raddr,
    input  cbpm_pkg::word_t       mask,
    output cbpm_pkg::edge_info_t  rinfo
);
    import cbpm_pkg::*;

    logic [2*WORD_W-1:0] mem [DEPTH];
    logic [2*WORD_W-1:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= {wtime, wdata};
        end
        rd_reg <= mem[raddr];
    end

    // sample is high when any observed bit is set
    assign rinfo.high  = |(rd_reg[WORD_W-1:0] & mask);
    assign rinfo.stamp = rd_reg[2*WORD_W-1:WORD_W];

endmodule

[src/cbpm_div.sv]
module cbpm_div #(
    parameter int TW = 38,
    parameter int PW = 6
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [TW-1:0]   dividend,
    input  logic [PW-1:0]   divisor,
    output logic            done,
    output cbpm_pkg::word_t quotient
);
    import cbpm_pkg::*;

    localparam int NW = $clog2(TW + 1);

    logic [TW-1:0] quo_reg, quo_next;
    logic [PW-1:0] rem_reg, rem_next;
    logic [PW-1:0] dvs_reg, dvs_next;
    logic [NW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [PW:0]   trial;
    logic          fits;

    assign trial = {rem_reg, quo_reg[TW-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = NW'(TW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // one restoring step per cycle
            if (fits)
            begin
                rem_next = PW'(trial - {1'b0, dvs_reg});
            end
            else
            begin
                rem_next = trial[PW-1:0];
            end
            quo_next = {quo_reg[TW-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == NW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg[WORD_W-1:0];

endmodule

[src/capture_buffer_period_meter.sv]
// Capture buffer with rising-edge period measurement.
// Input stream (s_*): one beat per operation: clear, record or measure.
// Output stream (m_*): exactly one beat per input beat, in order.
// Clear, record and unused opcodes answer one cycle after the input beat.
// A measure with fewer than two samples also answers in the next cycle.
// Otherwise a measure walks the buffer through states RD and EV for each
// stored sample (one memory read port, registered read data), then runs
// a restoring divider one quotient bit per cycle over 32+log2(DEPTH) bits.
// With no complete period the divider is skipped.
// s_tready is low while a measure is in progress and while a result
// beat waits on m_tready; a stalled result holds m_tdata stable.
// Reset empties the buffer (fill count zero) and drops any pending result;
// the sample memory itself is not cleared and needs no clearing pass.
module capture_buffer_period_meter #(
    parameter int DEPTH = 64
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // [1:0] opcode, [33:2] sample_data, [65:34] sample_time, [97:66] bit_mask
    input  logic [((cbpm_pkg::OP_W + 3*cbpm_pkg::WORD_W + 7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // [0] accepted, [32:1] avg_period, then fill_count
    output logic [((1 + cbpm_pkg::WORD_W + $clog2(DEPTH+1) + 7)/8)*8-1:0] m_tdata
);
    import cbpm_pkg::*;

    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int TW    = WORD_W + AW;
    localparam int OUT_W = ((1 + WORD_W + CW + 7) / 8) * 8;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_EV   = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] idx_reg, idx_next;
    word_t         mask_reg, mask_next;
    logic          prev_reg, prev_next;
    logic          have_reg, have_next;
    word_t         last_reg, last_next;
    logic [TW-1:0] total_reg, total_next;
    logic [AW-1:0] per_reg, per_next;
    logic          ov_reg, ov_next;
    logic          oacc_reg, oacc_next;
    word_t         oavg_reg, oavg_next;

    logic [OP_W-1:0] in_op;
    word_t           in_data, in_time, in_mask;
    logic            in_fire, out_free, mem_we, div_start, div_done, is_last;
    edge_info_t      rinfo;
    word_t           div_q, diff;

    assign in_op   = s_tdata[OP_W-1:0];
    assign in_data = s_tdata[OP_W +: WORD_W];
    assign in_time = s_tdata[OP_W+WORD_W +: WORD_W];
    assign in_mask = s_tdata[OP_W+2*WORD_W +: WORD_W];

    assign out_free = !ov_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign in_fire  = s_tvalid && s_tready;
    assign mem_we   = in_fire && (in_op == OP_RECORD) && (count_reg < CW'(DEPTH));
    assign diff     = last_reg - rinfo.stamp;
    assign is_last  = (CW'(idx_reg) + CW'(1)) == count_reg;

    cbpm_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (in_data),
        .wtime (in_time),
        .raddr (idx_reg),
        .mask  (mask_reg),
        .rinfo (rinfo)
    );

    cbpm_div #(
        .TW (TW),
        .PW (AW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (total_next),
        .divisor  (per_next),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        mask_next  = mask_reg;
        prev_next  = prev_reg;
        have_next  = have_reg;
        last_next  = last_reg;
        total_next = total_reg;
        per_next   = per_reg;
        ov_next    = ov_reg && !m_tready;
        oacc_next  = oacc_reg;
        oavg_next  = oavg_reg;
        div_start  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    oavg_next = '0;
                    oacc_next = 1'b1;
                    ov_next   = 1'b1;
                    case (in_op)
                        OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        OP_RECORD:
                        begin
                            if (mem_we)
                            begin
                                count_next = count_reg + 1'b1;
                            end
                            else
                            begin
                                oacc_next = 1'b0;
                            end
                        end
                        OP_MEASURE:
                        begin
                            if (count_reg >= CW'(2))
                            begin
                                ov_next    = 1'b0;
                                mask_next  = in_mask;
                                idx_next   = '0;
                                have_next  = 1'b0;
                                total_next = '0;
                                per_next   = '0;
                                state_next = ST_RD;
                            end
                        end
                        default:
                        begin
                            oacc_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_RD:
            begin
                state_next = ST_EV;
            end
            ST_EV:
            begin
                prev_next = rinfo.high;
                if ((idx_reg != '0) && !prev_reg && rinfo.high)
                begin
                    if (have_reg)
                    begin
                        total_next = total_reg + TW'(diff);
                        per_next   = per_reg + 1'b1;
                    end
                    last_next = rinfo.stamp;
                    have_next = 1'b1;
                end
                idx_next = idx_reg + 1'b1;
                if (is_last)
                begin
                    if (per_next == '0)
                    begin
                        oavg_next  = '0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
                else
                begin
                    state_next = ST_RD;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    oavg_next  = div_q;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    oacc_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        mask_reg  <= mask_next;
        prev_reg  <= prev_next;
        have_reg  <= have_next;
        last_reg  <= last_next;
        total_reg <= total_next;
        per_reg   <= per_next;
        oacc_reg  <= oacc_next;
        oavg_reg  <= oavg_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = OUT_W'({count_reg, oavg_reg, oacc_reg});

endmodule

[src/cbpm_chk.sv]
module cbpm_chk #(
    parameter int DEPTH = 64,
    parameter int IN_W  = 104,
    parameter int OUT_W = 40
) (
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic [IN_W-1:0]  s_tdata,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);
    import cbpm_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0] fill;

    assign fill = m_tdata[1+WORD_W +: CW];

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while result beat stalled");

    a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tdata[OP_W-1:0] == OP_CLEAR)
        |=> m_tvalid && m_tdata[0] && (fill == '0))
        else $error("clear did not answer with empty buffer");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> fill <= CW'(DEPTH))
        else $error("fill count beyond depth");

endmodule

bind capture_buffer_period_meter cbpm_chk #(
    .DEPTH (DEPTH),
    .IN_W  ($bits(s_tdata)),
    .OUT_W ($bits(m_tdata))
) u_cbpm_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[bench/tb.sv]
module tb;

    import cbpm_pkg::*;

    localparam int DEPTH      = 64;
    localparam int FILL_W     = $clog2(DEPTH + 1);
    localparam int S_W        = ((OP_W + 3*WORD_W + 7)/8)*8;
    localparam int M_W        = ((1 + WORD_W + FILL_W + 7)/8)*8;
    localparam int CYCLE_LIMIT = 2_000_000;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic              accepted;
        word_t             avg_period;
        logic [FILL_W-1:0] fill_count;
    } meter_result_t;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    // [1:0] opcode, [33:2] sample_data, [65:34] sample_time, [97:66] bit_mask
    logic [S_W-1:0] s_tdata = '0;
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [M_W-1:0] m_tdata;        // [0] accepted, [32:1] avg_period, [39:33] fill_count

    // Shadow of the capture buffer
    word_t data_log [DEPTH];
    word_t stamp_log [DEPTH];
    int    held_samples = 0;

    meter_result_t pending_results[$];
    int  error_count = 0;
    int  clock_ticks = 0;
    bit  tx_idle = 1'b1;
    bit  rx_idle = 1'b1;
    int  rx_hold_req = 0;
    int  rx_stall_left = 0;

    capture_buffer_period_meter #(.DEPTH(DEPTH)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic word_t predict_period(word_t mask);
        logic        prev_high;
        logic        cur_high;
        logic        rise_found;
        word_t       last_rise;
        logic [63:0] total;
        int          periods;
        if (held_samples < 2)
            return '0;
        prev_high = (data_log[0] & mask) != '0;
        rise_found = 1'b0;
        last_rise = '0;
        total = '0;
        periods = 0;
        for (int i = 1; i < held_samples; i++)
        begin
            cur_high = (data_log[i] & mask) != '0;
            if (!prev_high && cur_high)
            begin
                if (rise_found)
                begin
                    total += 64'(word_t'(last_rise - stamp_log[i]));
                    periods++;
                end
                last_rise = stamp_log[i];
                rise_found = 1'b1;
            end
            prev_high = cur_high;
        end
        if (periods == 0)
            return '0;
        return word_t'(total / 64'(periods));
    endfunction

    function automatic meter_result_t apply_op(logic [OP_W-1:0] op, word_t data, word_t stamp,
                                               word_t mask);
        meter_result_t res;
        res = '0;
        case (op)
            OP_CLEAR:
            begin
                held_samples = 0;
                res.accepted = 1'b1;
            end
            OP_RECORD:
            begin
                if (held_samples < DEPTH)
                begin
                    data_log[held_samples] = data;
                    stamp_log[held_samples] = stamp;
                    held_samples++;
                    res.accepted = 1'b1;
                end
            end
            OP_MEASURE:
            begin
                res.avg_period = predict_period(mask);
                res.accepted = 1'b1;
            end
            default:
            begin
            end
        endcase
        res.fill_count = FILL_W'(held_samples);
        return res;
    endfunction

    task automatic send_op(input logic [OP_W-1:0] op, input word_t data, input word_t stamp,
                           input word_t mask);
        logic [S_W-1:0] beat;
        beat = '0;
        beat[OP_W-1:0] = op;
        beat[OP_W +: WORD_W] = data;
        beat[OP_W+WORD_W +: WORD_W] = stamp;
        beat[OP_W+2*WORD_W +: WORD_W] = mask;
        pending_results.push_back(apply_op(op, data, stamp, mask));
        if (tx_idle && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        s_tdata <= beat;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    function automatic void check_beat(logic [M_W-1:0] beat);
        meter_result_t want;
        logic              got_accepted;
        word_t             got_avg;
        logic [FILL_W-1:0] got_fill;
        got_accepted = beat[0];
        got_avg = beat[1 +: WORD_W];
        got_fill = beat[1+WORD_W +: FILL_W];
        if (pending_results.size() == 0)
        begin
            $display("%0t: unexpected result beat %h", $realtime, beat);
            error_count++;
            return;
        end
        want = pending_results.pop_front();
        if (got_accepted !== want.accepted)
        begin
            $display("%0t: accepted mismatch: expected %0d, got %0d", $realtime,
                     want.accepted, got_accepted);
            error_count++;
        end
        if (got_avg !== want.avg_period)
        begin
            $display("%0t: avg_period mismatch: expected %0d, got %0d", $realtime,
                     want.avg_period, got_avg);
            error_count++;
        end
        if (got_fill !== want.fill_count)
        begin
            $display("%0t: fill_count mismatch: expected %0d, got %0d", $realtime,
                     want.fill_count, got_fill);
            error_count++;
        end
    endfunction

    // Result side: check each beat, drive m_tready with random stalls
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                check_beat(m_tdata);
            if (rx_hold_req > 0)
            begin
                rx_stall_left = rx_hold_req;
                rx_hold_req = 0;
            end
            else if (rx_stall_left == 0 && rx_idle && $urandom_range(0, 5) == 0)
                rx_stall_left = $urandom_range(1, 19);
            if (rx_stall_left > 0)
            begin
                m_tready <= 1'b0;
                rx_stall_left--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        while (clock_ticks < CYCLE_LIMIT)
        begin
            @(posedge clk);
            clock_ticks++;
        end
        $display("capture_buffer_period_meter test failed");
        $finish;
    end

    // One capture: clear, a run of records with a toggling watched bit, then measures
    task automatic run_capture(input int n_records);
        int    watch_bit;
        int    run_left;
        logic  level;
        word_t clean_mask;
        word_t stamp;
        word_t data;
        watch_bit = $urandom_range(0, 31);
        clean_mask = word_t'(1) << watch_bit;
        stamp = ($urandom_range(0, 3) == 0) ? word_t'($urandom_range(0, 20000)) : $urandom;
        level = 1'($urandom_range(0, 1));
        run_left = $urandom_range(1, 4);
        send_op(OP_CLEAR, $urandom, $urandom, $urandom);
        for (int i = 0; i < n_records; i++)
        begin
            data = ($urandom & ~clean_mask) | (level ? clean_mask : '0);
            send_op(OP_RECORD, data, stamp, $urandom);
            if ($urandom_range(0, 15) == 0)
                stamp = stamp - $urandom;
            else
                stamp = stamp - $urandom_range(1, 5000);
            run_left--;
            if (run_left == 0)
            begin
                level = ~level;
                run_left = $urandom_range(1, 4);
            end
        end
        send_op(OP_MEASURE, $urandom, $urandom, clean_mask);
        send_op(OP_MEASURE, $urandom, $urandom, $urandom);
        case ($urandom_range(0, 3))
            0: send_op(OP_MEASURE, $urandom, $urandom, '0);
            1: send_op(OP_MEASURE, $urandom, $urandom, '1);
            default: ;
        endcase
    endtask

    task automatic test_directed();
        send_op(OP_CLEAR, '0, '0, '0);
        send_op(OP_MEASURE, $urandom, $urandom, '1);           // empty buffer
        send_op(OP_RECORD, '1, '1, '0);                        // sample zero high
        send_op(OP_MEASURE, $urandom, $urandom, '1);           // single sample
        send_op(OP_UNUSED, $urandom, $urandom, $urandom);
        send_op(OP_RECORD, '0, '0, '1);
        send_op(OP_RECORD, 32'h1, 32'd100, '0);
        send_op(OP_MEASURE, '0, '0, 32'h1);                   // one rising edge only
        send_op(OP_RECORD, '0, 32'd50, '0);
        send_op(OP_RECORD, 32'h1, 32'hFFFF_FF00, '0);          // timer wrapped
        send_op(OP_MEASURE, '0, '0, 32'h1);
        send_op(OP_MEASURE, '0, '0, '0);
        send_op(OP_MEASURE, '0, '0, 32'h2);
        send_op(OP_MEASURE, '0, '0, '1);
        send_op(OP_RECORD, '0, 32'd10, '0);
        send_op(OP_RECORD, 32'h8000_0000, '0, '0);
        send_op(OP_MEASURE, '1, '1, 32'h8000_0001);            // sum above 32 bits
        send_op(OP_UNUSED, '1, '1, '1);
        send_op(OP_UNUSED, '0, '0, '0);
        send_op(OP_CLEAR, '1, '1, '1);
        send_op(OP_MEASURE, '1, '1, '1);
        send_op(OP_RECORD, 32'h5555_AAAA, 32'hAAAA_5555, '1);
    endtask

    task automatic test_full_buffer();
        run_capture(DEPTH + 3);
        send_op(OP_RECORD, $urandom, $urandom, $urandom);
        send_op(OP_MEASURE, $urandom, $urandom, $urandom);
    endtask

    task automatic test_backpressure();
        rx_hold_req = 400;
        for (int i = 0; i < 30; i++)
            send_op((i % 5 == 4) ? OP_MEASURE : OP_RECORD, $urandom, $urandom, $urandom);
    endtask

    task automatic test_random_captures();
        for (int s = 0; s < 75; s++)
        begin
            tx_idle = ($urandom_range(0, 4) != 0);
            rx_idle = ($urandom_range(0, 4) != 0);
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 6))
                    send_op(OP_W'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
            end
            if ($urandom_range(0, 7) == 0)
                run_capture($urandom_range(DEPTH, DEPTH + 3));
            else
                run_capture($urandom_range(0, 24));
        end
    endtask

    task automatic test_steady_stream();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        repeat (3)
            run_capture($urandom_range(2, 24));
        send_op(OP_UNUSED, $urandom, $urandom, $urandom);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_buffer();
        test_backpressure();
        test_random_captures();
        test_steady_stream();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (250) @(posedge clk);
        if (error_count == 0)
            $display("capture_buffer_period_meter test passed");
        else
            $display("capture_buffer_period_meter test failed");
        $finish;
    end

endmodule

[files.f]
src/cbpm_pkg.sv
src/cbpm_mem.sv
src/cbpm_div.sv
src/capture_buffer_period_meter.sv
src/cbpm_chk.sv
bench/tb.sv
